FILE: hdl/bmtw_pkg.sv
// ----------------------------------------------------------------------------
// bmtw_pkg: shared definitions for the bitmap text pixel writer
// Field widths, character codes, opcodes, register indexes and the cursor
// saturation helper.
// ----------------------------------------------------------------------------
package bmtw_pkg;

    // Glyph store geometry
    localparam int GLYPH_CODES   = 128;
    localparam int GLYPH_ROWS    = 8;
    localparam int GLYPH_ENTRIES = GLYPH_CODES * GLYPH_ROWS;
    localparam int CODE_AW       = $clog2(GLYPH_CODES);
    localparam int ROW_AW        = $clog2(GLYPH_ROWS);
    localparam int GLYPH_AW      = $clog2(GLYPH_ENTRIES);

    // Field widths
    localparam int OP_W     = 2;
    localparam int CODE_W   = 8;
    localparam int BITS_W   = 8;
    localparam int POS_W    = 16;
    localparam int COLOR_W  = 32;
    localparam int SIDE_W   = 13;
    localparam int PITCH_W  = 14;
    localparam int OFFSET_W = 25;
    localparam int CFG_AW   = 2;

    // Stream packing
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;

    // Cursor steps
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] CHAR_ADVANCE = STEP_W'(8);
    localparam logic [STEP_W-1:0] TAB_ADVANCE  = STEP_W'(8 * 4);

    // Character codes
    localparam logic [CODE_W-1:0] CODE_TAB        = 8'h09;
    localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_RETURN     = 8'h0D;
    localparam logic [CODE_W-1:0] LAST_DRAWN_CODE = 8'd127;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PITCH_WORDS   = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DRAW  = 2'd2
    } op_t;

    // Add a positive step to a signed cursor, clamp at the top limit
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] x,
        input logic [STEP_W-1:0]       inc
    );
        logic [POS_W:0] s;
        s = {x[POS_W-1], x} + {{(POS_W + 1 - STEP_W){1'b0}}, inc};
        if (!s[POS_W] && s[POS_W-1])
            sat_add = {1'b0, {(POS_W - 1){1'b1}}};
        else
            sat_add = s[POS_W-1:0];
    endfunction

endpackage

FILE: hdl/bmtw_serial_mul.sv
// ----------------------------------------------------------------------------
// bmtw_serial_mul: bit-serial shift-add multiplier
// Signed cursor line times pitch, modulo the offset width, one pitch bit
// per cycle.
// ----------------------------------------------------------------------------
module bmtw_serial_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [bmtw_pkg::POS_W-1:0]     mcand,
    input  logic        [bmtw_pkg::PITCH_W-1:0]   mplier,
    output logic                                  done,
    output logic        [bmtw_pkg::OFFSET_W-1:0]  product
);

    localparam int CNT_W = $clog2(bmtw_pkg::PITCH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bmtw_pkg::PITCH_W - 1);

    logic                            busy_reg,   busy_next;
    logic                            done_reg,   done_next;
    logic [CNT_W-1:0]                cnt_reg,    cnt_next;
    logic [bmtw_pkg::OFFSET_W-1:0]   acc_reg,    acc_next;
    logic [bmtw_pkg::OFFSET_W-1:0]   shift_reg,  shift_next;
    logic [bmtw_pkg::PITCH_W-1:0]    mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            shift_next  = {{(bmtw_pkg::OFFSET_W - bmtw_pkg::POS_W){mcand[bmtw_pkg::POS_W-1]}},
                           mcand};
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand where the pitch bit is set
            if (mplier_reg[0])
                acc_next = acc_reg + shift_reg;
            shift_next  = {shift_reg[bmtw_pkg::OFFSET_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[bmtw_pkg::PITCH_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        shift_reg  <= shift_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hdl/bitmap_text_pixel_writer.sv
// ----------------------------------------------------------------------------
// bitmap_text_pixel_writer: 8x8 bitmap font text to framebuffer pixel writes
// Loads glyph rows, tracks a text cursor and turns characters into clipped
// pixel write transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction; tuser holds the opcode
//   (load glyph row, start text, draw character). Load and start commands and
//   the control characters (newline, carriage return, tab) finish in the
//   cycle they are accepted and produce no output.
//   A drawable character (code 0..127) first runs a bit-serial multiply of
//   the cursor line by the pitch, then scans its 8x8 glyph one column per
//   cycle while the master side does not stall, then flushes; the slave side
//   stays low until the flush is done and the next command can be accepted.
//   The glyph store is a 1024 x 8 memory with a registered read port; the
//   next row is fetched while the current row finishes, so the column scan
//   never waits.
//   Master stream carries one pixel write per transaction: word offset and
//   color in tdata, tlast on the character's final visible pixel. One pixel
//   is held back so tlast is known when it leaves.
//   A stalled master side holds its transaction and, once the holding
//   register is also full, freezes the scan. The slave side is ready only
//   between characters; the last pixel may still wait at the output then.
//   Reset clears the cursor, color and control state and loads the screen
//   registers with 640 x 480, pitch 640. The glyph store is not cleared.
// ----------------------------------------------------------------------------
module bitmap_text_pixel_writer (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [bmtw_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [bmtw_pkg::PITCH_W-1:0]        cfg_data,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_code[7:0], glyph_row[10:8], row_bits[18:11], pos_x[34:19],
    // pos_y[50:35], color[82:51], zero[87:83]
    input  logic [bmtw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[1:0]
    input  logic [bmtw_pkg::OP_W-1:0]           s_axis_tuser,
    // pixel stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_offset[24:0], pixel_color[56:25], zero[63:57]
    output logic [bmtw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int PW = bmtw_pkg::POS_W;
    localparam int OW = bmtw_pkg::OFFSET_W;
    localparam int RW = bmtw_pkg::ROW_AW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Input field unpacking
    logic [bmtw_pkg::CODE_W-1:0]   in_code;
    logic [RW-1:0]                 in_row;
    logic [bmtw_pkg::BITS_W-1:0]   in_bits;
    logic signed [PW-1:0]          in_pos_x;
    logic signed [PW-1:0]          in_pos_y;
    logic [bmtw_pkg::COLOR_W-1:0]  in_color;
    bmtw_pkg::op_t                 in_op;

    assign in_code  = s_axis_tdata[7:0];
    assign in_row   = s_axis_tdata[10:8];
    assign in_bits  = s_axis_tdata[18:11];
    assign in_pos_x = s_axis_tdata[34:19];
    assign in_pos_y = s_axis_tdata[50:35];
    assign in_color = s_axis_tdata[82:51];
    assign in_op    = bmtw_pkg::op_t'(s_axis_tuser);

    // Registers
    state_t                        state_reg,     state_next;
    logic signed [PW-1:0]          cur_x_reg,     cur_x_next;
    logic signed [PW-1:0]          cur_y_reg,     cur_y_next;
    logic signed [PW-1:0]          line_x_reg,    line_x_next;
    logic [bmtw_pkg::COLOR_W-1:0]  color_reg,     color_next;
    logic [bmtw_pkg::SIDE_W-1:0]   width_reg,     width_next;
    logic [bmtw_pkg::SIDE_W-1:0]   height_reg,    height_next;
    logic [bmtw_pkg::PITCH_W-1:0]  pitch_reg,     pitch_next;
    logic [bmtw_pkg::CODE_AW-1:0]  code_reg,      code_next;
    logic [RW-1:0]                 row_reg,       row_next;
    logic [RW-1:0]                 col_reg,       col_next;
    logic signed [PW:0]            px_reg,        px_next;
    logic signed [PW:0]            py_reg,        py_next;
    logic [OW-1:0]                 base_reg,      base_next;
    logic                          pend_vld_reg,  pend_vld_next;
    logic [OW-1:0]                 pend_off_reg,  pend_off_next;
    logic                          out_vld_reg,   out_vld_next;
    logic [OW-1:0]                 out_off_reg,   out_off_next;
    logic [bmtw_pkg::COLOR_W-1:0]  out_color_reg, out_color_next;
    logic                          out_last_reg,  out_last_next;

    // Glyph store
    logic [bmtw_pkg::BITS_W-1:0]   glyph_mem [bmtw_pkg::GLYPH_ENTRIES];
    logic [bmtw_pkg::BITS_W-1:0]   glyph_q_reg;
    logic                          mem_we;
    logic [bmtw_pkg::GLYPH_AW-1:0] wr_addr;
    logic [bmtw_pkg::GLYPH_AW-1:0] rd_addr;

    // Multiplier handshake
    logic                          mul_start;
    logic                          mul_done;
    logic [OW-1:0]                 mul_product;

    // Scan datapath
    logic                          accept;
    logic                          code_fits;
    logic                          out_free;
    logic                          cur_bit;
    logic                          visible;
    logic                          stall;
    logic [OW-1:0]                 cand_off;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign code_fits = {1'b0, in_code} < (bmtw_pkg::CODE_W + 1)'(bmtw_pkg::GLYPH_CODES);
    assign out_free  = !out_vld_reg || m_axis_tready;

    assign cur_bit  = glyph_q_reg[col_reg];
    assign visible  = cur_bit && !px_reg[PW] && !py_reg[PW]
                   && (px_reg[PW-1:0] < PW'(width_reg))
                   && (py_reg[PW-1:0] < PW'(height_reg));
    assign cand_off = base_reg + OW'(px_reg[PW-1:0]);
    // a second visible pixel needs the held one to move out first
    assign stall    = visible && pend_vld_reg && !out_free;

    assign wr_addr = {in_code[bmtw_pkg::CODE_AW-1:0], in_row};
    // fetch the row that is current after this edge
    assign rd_addr = {code_reg, row_next};

    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        line_x_next    = line_x_reg;
        color_next     = color_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        pitch_next     = pitch_reg;
        code_next      = code_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        base_next      = base_reg;
        pend_vld_next  = pend_vld_reg;
        pend_off_next  = pend_off_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        out_off_next   = out_off_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mul_start      = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                bmtw_pkg::CFG_SCREEN_WIDTH:  width_next  = cfg_data[bmtw_pkg::SIDE_W-1:0];
                bmtw_pkg::CFG_SCREEN_HEIGHT: height_next = cfg_data[bmtw_pkg::SIDE_W-1:0];
                bmtw_pkg::CFG_PITCH_WORDS:   pitch_next  = cfg_data;
                default:                     ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        bmtw_pkg::OP_LOAD:
                        begin
                            mem_we = code_fits;
                        end
                        bmtw_pkg::OP_START:
                        begin
                            cur_x_next  = in_pos_x;
                            cur_y_next  = in_pos_y;
                            line_x_next = in_pos_x;
                            color_next  = in_color;
                        end
                        bmtw_pkg::OP_DRAW:
                        begin
                            if (in_code == bmtw_pkg::CODE_NEWLINE)
                            begin
                                cur_y_next = bmtw_pkg::sat_add(cur_y_reg, bmtw_pkg::CHAR_ADVANCE);
                                cur_x_next = line_x_reg;
                            end
                            else if (in_code == bmtw_pkg::CODE_RETURN)
                                cur_x_next = line_x_reg;
                            else if (in_code == bmtw_pkg::CODE_TAB)
                                cur_x_next = bmtw_pkg::sat_add(cur_x_reg, bmtw_pkg::TAB_ADVANCE);
                            else if (in_code <= bmtw_pkg::LAST_DRAWN_CODE && code_fits)
                            begin
                                // start the glyph: line base first, then the scan
                                code_next  = in_code[bmtw_pkg::CODE_AW-1:0];
                                row_next   = '0;
                                col_next   = '0;
                                px_next    = {cur_x_reg[PW-1], cur_x_reg};
                                py_next    = {cur_y_reg[PW-1], cur_y_reg};
                                mul_start  = 1'b1;
                                state_next = ST_MUL;
                            end
                            else
                                cur_x_next = bmtw_pkg::sat_add(cur_x_reg, bmtw_pkg::CHAR_ADVANCE);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    base_next  = mul_product;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (visible)
                    begin
                        // hand the held pixel on, hold the new one
                        if (pend_vld_reg)
                        begin
                            out_vld_next   = 1'b1;
                            out_off_next   = pend_off_reg;
                            out_color_next = color_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_off_next = cand_off;
                    end
                    if (col_reg == RW'(bmtw_pkg::GLYPH_ROWS - 1))
                    begin
                        col_next  = '0;
                        px_next   = {cur_x_reg[PW-1], cur_x_reg};
                        row_next  = row_reg + 1'b1;
                        py_next   = py_reg + (PW + 1)'(1);
                        base_next = base_reg + OW'(pitch_reg);
                        if (row_reg == RW'(bmtw_pkg::GLYPH_ROWS - 1))
                            state_next = ST_FLUSH;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        px_next  = px_reg + (PW + 1)'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next   = 1'b1;
                        out_off_next   = pend_off_reg;
                        out_color_next = color_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    cur_x_next    = bmtw_pkg::sat_add(cur_x_reg, bmtw_pkg::CHAR_ADVANCE);
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            line_x_reg   <= '0;
            color_reg    <= '0;
            width_reg    <= bmtw_pkg::SIDE_W'(640);
            height_reg   <= bmtw_pkg::SIDE_W'(480);
            pitch_reg    <= bmtw_pkg::PITCH_W'(640);
            row_reg      <= '0;
            col_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            line_x_reg   <= line_x_next;
            color_reg    <= color_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            pitch_reg    <= pitch_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        base_reg      <= base_next;
        pend_off_reg  <= pend_off_next;
        out_off_reg   <= out_off_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    // Glyph store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            glyph_mem[wr_addr] <= in_bits;
        glyph_q_reg <= glyph_mem[rd_addr];
    end

    bmtw_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (cur_y_reg),
        .mplier  (pitch_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(bmtw_pkg::OUT_DATA_W - OW - bmtw_pkg::COLOR_W)'(0),
                            out_color_reg, out_off_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hdl/bmtw_checker.sv
// ----------------------------------------------------------------------------
// bmtw_checker: port-level checks for the bitmap text pixel writer
// Watches both streams and flags ordering and holding slips.
// ----------------------------------------------------------------------------
module bmtw_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [bmtw_pkg::OP_W-1:0]           s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bmtw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast
);

    // hold a stalled pixel transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled pixel transaction changed");

    // between characters only a final pixel may still wait
    a_idle_tail: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tlast)
        else $error("non-final pixel pending while accepting commands");

    // load and start commands never produce a pixel
    a_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
            && (s_axis_tuser != bmtw_pkg::OP_DRAW) |=> !m_axis_tvalid)
        else $error("pixel produced by a non-draw command");

    // padding above the color stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bmtw_pkg::OUT_DATA_W-1:
            bmtw_pkg::OFFSET_W + bmtw_pkg::COLOR_W] == '0))
        else $error("pixel padding bits not zero");

endmodule

bind bitmap_text_pixel_writer bmtw_checker u_bmtw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/bitmap_text_pixel_writer_checker.sv
// ----------------------------------------------------------------------------
// bitmap_text_pixel_writer_checker: pixel write predictor and scoreboard
// Watches the configuration port and both streams, keeps its own cursor,
// color, screen registers and glyph rows, and compares every pixel write
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module bitmap_text_pixel_writer_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bmtw_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [bmtw_pkg::PITCH_W-1:0]        cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [bmtw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [bmtw_pkg::OP_W-1:0]           s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bmtw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast,
    output int                                  mismatch_count,
    output int                                  pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    import bmtw_pkg::*;

    localparam int ROW_LSB   = CODE_W;
    localparam int BITS_LSB  = ROW_LSB + ROW_AW;
    localparam int PX_LSB    = BITS_LSB + BITS_W;
    localparam int PY_LSB    = PX_LSB + POS_W;
    localparam int COLOR_LSB = PY_LSB + POS_W;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } pixel_write_t;

    logic [SIDE_W-1:0]        width_reg;
    logic [SIDE_W-1:0]        height_reg;
    logic [PITCH_W-1:0]       pitch_reg;
    logic signed [POS_W-1:0]  cur_x;
    logic signed [POS_W-1:0]  cur_y;
    logic signed [POS_W-1:0]  line_x;
    logic [COLOR_W-1:0]       ink;
    logic [BITS_W-1:0]        glyph_rows [GLYPH_ENTRIES];
    pixel_write_t             queued_pixels [$];

    initial
    begin
        mismatch_count = 0;
        pending_pixels = 0;
        for (int i = 0; i < GLYPH_ENTRIES; i++)
            glyph_rows[i] = '0;
    end

    function automatic logic signed [POS_W-1:0] clamp_cursor(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return POS_W'(v);
    endfunction

    // Walk the glyph row by row, column by column; hold one write back so
    // the final visible pixel can be flagged
    task automatic queue_glyph(input logic [CODE_W-1:0] code);
        pixel_write_t      held;
        bit                have_held;
        logic [BITS_W-1:0] bits;
        int                px;
        int                py;
        longint            off;
        have_held = 1'b0;
        held = '0;
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            bits = glyph_rows[int'(code) * GLYPH_ROWS + row];
            py = int'(cur_y) + row;
            for (int col = 0; col < BITS_W; col++)
            begin
                px = int'(cur_x) + col;
                if (bits[col] && px >= 0 && py >= 0 &&
                    px < int'(width_reg) && py < int'(height_reg))
                begin
                    if (have_held)
                        queued_pixels.push_back(held);
                    off = longint'(py) * longint'(pitch_reg) + longint'(px);
                    held.offset = off[OFFSET_W-1:0];
                    held.color = ink;
                    held.last = 1'b0;
                    have_held = 1'b1;
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            queued_pixels.push_back(held);
        end
    endtask

    task automatic apply_command(input logic [OP_W-1:0] op,
                                 input logic [IN_DATA_W-1:0] data);
        logic [CODE_W-1:0] code;
        logic [ROW_AW-1:0] row;
        code = data[CODE_W-1:0];
        row = data[BITS_LSB-1:ROW_LSB];
        case (op)
            OP_LOAD:
            begin
                // codes past the store are dropped
                if (code < GLYPH_CODES)
                    glyph_rows[int'(code) * GLYPH_ROWS + int'(row)] = data[PX_LSB-1:BITS_LSB];
            end
            OP_START:
            begin
                cur_x = data[PY_LSB-1:PX_LSB];
                cur_y = data[COLOR_LSB-1:PY_LSB];
                line_x = data[PY_LSB-1:PX_LSB];
                ink = data[COLOR_LSB+COLOR_W-1:COLOR_LSB];
            end
            OP_DRAW:
            begin
                if (code == CODE_NEWLINE)
                begin
                    cur_y = clamp_cursor(int'(cur_y) + int'(CHAR_ADVANCE));
                    cur_x = line_x;
                end
                else if (code == CODE_RETURN)
                    cur_x = line_x;
                else if (code == CODE_TAB)
                    cur_x = clamp_cursor(int'(cur_x) + int'(TAB_ADVANCE));
                else
                begin
                    // high codes only move the cursor
                    if (code <= LAST_DRAWN_CODE && code < GLYPH_CODES)
                        queue_glyph(code);
                    cur_x = clamp_cursor(int'(cur_x) + int'(CHAR_ADVANCE));
                end
            end
            default:
            begin
                // unused opcode: no effect
            end
        endcase
    endtask

    task automatic check_pixel();
        pixel_write_t got;
        pixel_write_t want;
        got.offset = m_axis_tdata[OFFSET_W-1:0];
        got.color = m_axis_tdata[OFFSET_W+COLOR_W-1:OFFSET_W];
        got.last = m_axis_tlast;
        if (queued_pixels.size() == 0)
        begin
            $display("%0t: unexpected pixel write offset %h color %h last %b",
                     $time, got.offset, got.color, got.last);
            mismatch_count++;
        end
        else
        begin
            want = queued_pixels.pop_front();
            if (got.offset !== want.offset)
            begin
                $display("%0t: pixel_offset expected %h actual %h",
                         $time, want.offset, got.offset);
                mismatch_count++;
            end
            if (got.color !== want.color)
            begin
                $display("%0t: pixel_color expected %h actual %h",
                         $time, want.color, got.color);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_pixel expected %b actual %b",
                         $time, want.last, got.last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = SIDE_W'(640);
            height_reg = SIDE_W'(480);
            pitch_reg = PITCH_W'(640);
            cur_x = '0;
            cur_y = '0;
            line_x = '0;
            ink = '0;
            queued_pixels.delete();
            pending_pixels = 0;
        end
        else
        begin
            // a pixel leaving now belongs to an earlier character
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg = cfg_data[SIDE_W-1:0];
                    CFG_SCREEN_HEIGHT: height_reg = cfg_data[SIDE_W-1:0];
                    CFG_PITCH_WORDS:   pitch_reg = cfg_data;
                    default:           ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata);
            pending_pixels = queued_pixels.size();
        end
    end

endmodule

FILE: tb/bitmap_text_pixel_writer_tb.sv
// ----------------------------------------------------------------------------
// bitmap_text_pixel_writer_tb: stimulus and verdict for the text pixel writer
// Loads glyphs, positions text and streams characters under random stalls on
// both streams, across several screen and pitch settings; the checker beside
// the block predicts and compares every pixel write.
// ----------------------------------------------------------------------------
module bitmap_text_pixel_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmtw_pkg::*;

    // tuser value with no command behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 44;
    localparam int STALL_PCT   = 38;
    // A character whose pixels are all clipped away runs with no transaction
    // at all, and gaps and stalls lengthen that quiet stretch further
    localparam int IDLE_LIMIT  = 2000;
    // Drain time after the last pixel: a character that draws nothing may
    // still be scanning
    localparam int SETTLE      = 120;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_AW-1:0]      cfg_index = '0;
    logic [PITCH_W-1:0]     cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    int                     mismatch_count;
    int                     pending_pixels;

    bit                     steady = 1'b0;
    int                     items_sent = 0;
    int                     idle_cycles = 0;
    int                     view_w = 640;
    int                     view_h = 480;
    logic [GLYPH_ROWS-1:0]  rows_loaded [GLYPH_CODES];
    int                     ready_codes [$];

    bitmap_text_pixel_writer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bitmap_text_pixel_writer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .pending_pixels (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pixel side: stall at random, never during the steady stretch
    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= STALL_PCT);

    // Watchdog: end the run after too long without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bitmap_text_pixel_writer verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // char_code, glyph_row, row_bits, pos_x, pos_y, color from the low bits
    function automatic logic [IN_DATA_W-1:0] pack_command(
        input logic [CODE_W-1:0]  code,
        input logic [ROW_AW-1:0]  row,
        input logic [BITS_W-1:0]  bits,
        input logic [POS_W-1:0]   px,
        input logic [POS_W-1:0]   py,
        input logic [COLOR_W-1:0] color
    );
        return {5'b0, color, py, px, bits, row, code};
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transaction with tvalid still high so back-to-back commands keep it up
    task automatic push_item(input logic [OP_W-1:0] op,
                             input logic [IN_DATA_W-1:0] data);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Track complete glyphs so a draw never reads a row that was not loaded
    task automatic load_row(input int code, input int row, input logic [BITS_W-1:0] bits);
        bit was_ready;
        push_item(OP_LOAD, pack_command(CODE_W'(code), ROW_AW'(row), bits, '0, '0, '0));
        if (code < GLYPH_CODES)
        begin
            was_ready = (rows_loaded[code] == '1);
            rows_loaded[code][row] = 1'b1;
            if (!was_ready && rows_loaded[code] == '1)
                ready_codes.push_back(code);
        end
    endtask

    task automatic load_glyph(input int code);
        bit blank;
        blank = ($urandom_range(4) == 0);
        for (int r = 0; r < GLYPH_ROWS; r++)
            load_row(code, r, blank ? 8'h00 : BITS_W'($urandom));
    endtask

    task automatic start_text(input int x, input int y, input logic [COLOR_W-1:0] color);
        push_item(OP_START, pack_command('0, '0, '0, POS_W'(x), POS_W'(y), color));
    endtask

    task automatic send_char(input int code);
        push_item(OP_DRAW, pack_command(CODE_W'(code), '0, '0, '0, '0, '0));
    endtask

    // Drop tvalid, drain every predicted pixel, then give the block time to
    // finish a character that draws nothing
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic configure(input int w, input int h, input int p);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data <= PITCH_W'(w);
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data <= PITCH_W'(h);
        @(negedge clk);
        cfg_index <= CFG_PITCH_WORDS;
        cfg_data <= PITCH_W'(p);
        @(negedge clk);
        cfg_we <= 1'b0;
        view_w = w;
        view_h = h;
    endtask

    // One random step: mostly well-formed glyph loads, text starts and
    // draws of complete glyphs, with a share of noise
    task automatic random_step();
        int pick;
        int sel;
        int x;
        int y;
        pick = $urandom_range(99);
        if (pick < 14)
            load_glyph($urandom_range(GLYPH_CODES - 1));
        else if (pick < 26)
        begin
            if ($urandom_range(99) < 85)
            begin
                x = int'($urandom_range(view_w + 15)) - 8;
                y = int'($urandom_range(view_h + 15)) - 8;
            end
            else
            begin
                x = int'($urandom_range(65535)) - 32768;
                y = int'($urandom_range(65535)) - 32768;
            end
            start_text(x, y, $urandom);
        end
        else if (pick < 34)
        begin
            sel = $urandom_range(2);
            if (sel == 0)
                load_row($urandom_range(255, GLYPH_CODES), $urandom_range(7), BITS_W'($urandom));
            else if (sel == 1)
                push_item(OP_UNUSED, pack_command(CODE_W'($urandom), ROW_AW'($urandom),
                                                  BITS_W'($urandom), POS_W'($urandom),
                                                  POS_W'($urandom), $urandom));
            else
                load_row($urandom_range(GLYPH_CODES - 1), $urandom_range(7),
                         BITS_W'($urandom));
        end
        else
        begin
            sel = $urandom_range(99);
            if (sel < 70 && ready_codes.size() != 0)
                send_char(ready_codes[$urandom_range(ready_codes.size() - 1)]);
            else if (sel < 85 || ready_codes.size() == 0)
            begin
                case ($urandom_range(2))
                    0:       send_char(CODE_TAB);
                    1:       send_char(CODE_NEWLINE);
                    default: send_char(CODE_RETURN);
                endcase
            end
            else
                send_char($urandom_range(255, int'(LAST_DRAWN_CODE) + 1));
        end
    endtask

    initial
    begin
        int phase_base;
        for (int c = 0; c < GLYPH_CODES; c++)
            rows_loaded[c] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on the reset screen of 640 x 480, pitch 640
        for (int r = 0; r < GLYPH_ROWS; r++)
            load_row(LAST_DRAWN_CODE, r, 8'hFF);        // dense glyph, 64 pixels
        load_row(200, 3, 8'hA5);                        // code past the store
        push_item(OP_UNUSED, pack_command(8'h41, 3'd5, 8'hFF, 16'h1234, 16'h5678,
                                          32'hDEAD_BEEF));
        start_text(0, 0, 32'hFFFF_FFFF);
        send_char(LAST_DRAWN_CODE);
        send_char(CODE_TAB);
        send_char(CODE_NEWLINE);
        send_char(CODE_RETURN);
        send_char(255);                                 // advance only
        send_char(LAST_DRAWN_CODE);
        start_text(-4, -4, 32'h0000_0000);              // clip top and left
        send_char(LAST_DRAWN_CODE);
        start_text(636, 476, 32'h1234_5678);            // clip right and bottom
        send_char(LAST_DRAWN_CODE);
        start_text(32767, 32767, 32'hA5A5_A5A5);        // cursor saturation
        send_char(CODE_TAB);
        send_char(CODE_NEWLINE);
        send_char(LAST_DRAWN_CODE);
        start_text(-32768, -32768, 32'h5A5A_5A5A);
        send_char(LAST_DRAWN_CODE);

        // Random part over several screen settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure(4096, 4096, 8192);
                1: configure(1, 1, 1);
                2: configure(8191, 8191, 16383);        // offsets wrap
                3: configure(100, 60, 0);               // offset is x alone
                4: configure(0, 200, 300);              // nothing visible
                5: configure(320, 0, 320);
                6: configure($urandom_range(4096, 1), $urandom_range(4096, 1),
                             $urandom_range(8192, 1));
                default:
                begin
                    configure(640, 480, 640);
                    steady <= 1'b1;                     // no stalls on either side
                end
            endcase
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS)
                random_step();
        end

        wait_idle();
        if (mismatch_count == 0 && pending_pixels == 0)
            $display("bitmap_text_pixel_writer verification clean");
        else
            $display("bitmap_text_pixel_writer verification failed");
        $finish;
    end

endmodule
